[design/point_segment_squared_distance_top_assert.svh]
// Assertion macros for the point to segment distance block.
`ifndef POINT_SEGMENT_SQUARED_DISTANCE_TOP_ASSERT_SVH
`define POINT_SEGMENT_SQUARED_DISTANCE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PSD_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
`define PSD_ASSERT_NXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`else
`define PSD_ASSERT_IMP(label, clk, rst, a, b)
`define PSD_ASSERT_NXT(label, clk, rst, a, b)
`endif
`endif

[design/psd_pkg.sv]
// ---------------------------------------------------------------------------
// psd_pkg
// Shared constants of the point to segment distance block.
// ---------------------------------------------------------------------------
`default_nettype none
package psd_pkg;
   localparam logic [1:0] REGION_START    = 2'd0;
   localparam logic [1:0] REGION_END      = 2'd1;
   localparam logic [1:0] REGION_INTERIOR = 2'd2;
endpackage
`default_nettype wire

[design/psd_if.sv]
// ---------------------------------------------------------------------------
// psd_if
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
`default_nettype none
interface psd_if #(parameter int W = 8);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[design/point_segment_squared_distance_top.sv]
// ---------------------------------------------------------------------------
// point_segment_squared_distance_top
// Squared distance from a 3-D point to a segment in fixed point; p*p/L is floored.
// ---------------------------------------------------------------------------
// One item enters per cycle while the output register is free or being
// taken. Three front stages form differences, products and dot sums, one
// stage squares the projection from half-width partial products, then a
// chain of one-bit division cells takes floor(p*p/L), and an output
// register holds the result. All stages advance together while the output
// register is free or being taken, so a stalled sink halts the chain.
`default_nettype none
`include "point_segment_squared_distance_top_assert.svh"
module point_segment_squared_distance_top
   import psd_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input wire logic clock,
   input wire logic reset,
   psd_if.sink   req,
   psd_if.source rsp
);
   localparam int CB = COORD_BITS;
   localparam int VB = CB + 1;          // difference width
   localparam int DB = 2*CB + 2;        // distance width
   localparam int PB = 2*VB + 2;        // dot product width, signed
   localparam int QW = 2*DB;            // p*p width
   localparam int NC = QW;              // division cells
   localparam int CW = DB + DB + 2;     // context: sqa, sqb, region
   localparam int LO = PB / 2;          // low half of the projection

   logic en;
   logic out_vld_ff;
   assign en        = !out_vld_ff || rsp.ready;
   assign req.ready = en;

   // stage 1: vectors
   logic s1_vld_ff;
   logic signed [VB-1:0] d_ff [3], a_ff [3], b_ff [3];
   // stage 2: products
   logic s2_vld_ff;
   logic signed [2*VB-1:0] pd_ff [3], aa_ff [3], bb_ff [3], dd_ff [3];
   // stage 3: sums
   logic s3_vld_ff;
   logic signed [PB-1:0] proj_ff;
   logic [DB-1:0] sqa3_ff, sqb3_ff, sql3_ff;
   // stage 4: square projection
   logic s4_vld_ff;
   logic [QW-1:0] pp_ff;
   logic [DB-1:0] sql4_ff;
   logic [CW-1:0] ctx4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s1_vld_ff <= req.valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            d_ff[k] <= VB'($signed(req.data[(3+k)*CB +: CB]))
                     - VB'($signed(req.data[k*CB +: CB]));
            a_ff[k] <= VB'($signed(req.data[(6+k)*CB +: CB]))
                     - VB'($signed(req.data[k*CB +: CB]));
            b_ff[k] <= VB'($signed(req.data[(6+k)*CB +: CB]))
                     - VB'($signed(req.data[(3+k)*CB +: CB]));
            pd_ff[k] <= (2*VB)'(a_ff[k]) * (2*VB)'(d_ff[k]);
            aa_ff[k] <= (2*VB)'(a_ff[k]) * (2*VB)'(a_ff[k]);
            bb_ff[k] <= (2*VB)'(b_ff[k]) * (2*VB)'(b_ff[k]);
            dd_ff[k] <= (2*VB)'(d_ff[k]) * (2*VB)'(d_ff[k]);
         end
         proj_ff <= PB'(pd_ff[0]) + PB'(pd_ff[1]) + PB'(pd_ff[2]);
         sqa3_ff <= DB'(aa_ff[0]) + DB'(aa_ff[1]) + DB'(aa_ff[2]);
         sqb3_ff <= DB'(bb_ff[0]) + DB'(bb_ff[1]) + DB'(bb_ff[2]);
         sql3_ff <= DB'(dd_ff[0]) + DB'(dd_ff[1]) + DB'(dd_ff[2]);
      end
   end

   // region decision and p*p
   logic [1:0] region3;
   logic [PB-1:0] pabs;
   logic [LO-1:0] p_lo;
   logic [PB-LO-1:0] p_hi;
   logic [QW-1:0] pp_ll, pp_lh, pp_hh, pp_sum;
   always_comb begin
      pabs = proj_ff;
      if (proj_ff <= 0) region3 = REGION_START;
      else if (PB'(sql3_ff) <= proj_ff) region3 = REGION_END;
      else region3 = REGION_INTERIOR;
      // p*p = hi*hi << 2LO + 2*hi*lo << LO + lo*lo
      p_lo   = pabs[LO-1:0];
      p_hi   = pabs[PB-1:LO];
      pp_ll  = QW'(p_lo) * QW'(p_lo);
      pp_lh  = QW'(p_hi) * QW'(p_lo);
      pp_hh  = QW'(p_hi) * QW'(p_hi);
      pp_sum = pp_ll + (pp_lh << (LO + 1)) + (pp_hh << (2 * LO));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pp_ff   <= (region3 == REGION_INTERIOR) ? pp_sum : '0;
         sql4_ff <= (region3 == REGION_INTERIOR) ? sql3_ff : DB'(1);
         ctx4_ff <= {sqa3_ff, sqb3_ff, region3};
      end
   end

   // division chain
   logic          c_vld [NC+1];
   logic [QW-1:0] c_num [NC+1];
   logic [DB:0]   c_rem [NC+1];
   logic [DB-1:0] c_den [NC+1];
   logic [CW-1:0] c_ctx [NC+1];
   assign c_vld[0] = s4_vld_ff;
   assign c_num[0] = pp_ff;
   assign c_rem[0] = '0;
   assign c_den[0] = sql4_ff;
   assign c_ctx[0] = ctx4_ff;

   for (genvar g = 0; g < NC; g++) begin : g_cell
      psd_div_cell #(.QW(QW), .DW(DB), .CW(CW)) u_cell (
         .clock(clock), .reset(reset), .en(en),
         .vld_in(c_vld[g]), .num_in(c_num[g]), .rem_in(c_rem[g]),
         .den_in(c_den[g]), .ctx_in(c_ctx[g]),
         .vld_out(c_vld[g+1]), .num_out(c_num[g+1]), .rem_out(c_rem[g+1]),
         .den_out(c_den[g+1]), .ctx_out(c_ctx[g+1])
      );
   end

   // output register
   logic [DB-1:0] sqa_e, sqb_e, dist_sel;
   logic [1:0]    reg_e;
   logic [DB-1:0] out_dist_ff;
   logic [1:0]    out_reg_ff;
   always_comb begin
      sqa_e = c_ctx[NC][CW-1 -: DB];
      sqb_e = c_ctx[NC][DB+1 : 2];
      reg_e = c_ctx[NC][1:0];
      unique case (reg_e)
         REGION_START: dist_sel = sqa_e;
         REGION_END:   dist_sel = sqb_e;
         default:      dist_sel = sqa_e - c_num[NC][DB-1:0];
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= c_vld[NC];
      end
      if (en) begin
         out_dist_ff <= dist_sel;
         out_reg_ff  <= reg_e;
      end
   end
   assign rsp.valid = out_vld_ff;
   assign rsp.data  = {out_reg_ff, out_dist_ff};

   `PSD_ASSERT_IMP(a_no_region3, clock, reset, rsp.valid, out_reg_ff != 2'd3)
   `PSD_ASSERT_IMP(a_ready, clock, reset, !rsp.valid, req.ready)
   `PSD_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready,
                   rsp.valid && $stable(rsp.data))
endmodule
`default_nettype wire

[design/psd_div_cell.sv]
// ---------------------------------------------------------------------------
// psd_div_cell
// One restoring-division step; passes the item's context to its neighbor.
// ---------------------------------------------------------------------------
`default_nettype none
module psd_div_cell
   import psd_pkg::*;
#(
   parameter int QW = 68,
   parameter int DW = 50,
   parameter int CW = 40
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          en,
   input  wire logic          vld_in,
   input  wire logic [QW-1:0] num_in,
   input  wire logic [DW:0]   rem_in,
   input  wire logic [DW-1:0] den_in,
   input  wire logic [CW-1:0] ctx_in,
   output logic               vld_out,
   output logic [QW-1:0]      num_out,
   output logic [DW:0]        rem_out,
   output logic [DW-1:0]      den_out,
   output logic [CW-1:0]      ctx_out
);
   logic [DW+1:0] trial;
   logic [DW:0]   rem_in_w;
   logic          ge;
   logic vld_ff;
   logic [QW-1:0] num_ff;
   logic [DW:0]   rem_ff;
   logic [DW-1:0] den_ff;
   logic [CW-1:0] ctx_ff;

   always_comb begin
      trial    = {rem_in, num_in[QW-1]};
      ge       = trial >= {2'b0, den_in};
      rem_in_w = ge ? (DW+1)'(trial - {2'b0, den_in}) : trial[DW:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
      if (en) begin
         num_ff <= {num_in[QW-2:0], ge};
         rem_ff <= rem_in_w;
         den_ff <= den_in;
         ctx_ff <= ctx_in;
      end
   end
   assign vld_out = vld_ff;
   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign den_out = den_ff;
   assign ctx_out = ctx_ff;
endmodule
`default_nettype wire
